### sv/mqttpsp_pkg.sv
// Package for the MQTT PUBLISH stream parser.
// Holds limits, parse phase codes, status codes, byte kinds and item widths.
// No dependencies.
`timescale 1ns / 1ps

package mqttpsp_pkg;

  // Limits of the parser.
  localparam int unsigned MaxTopic = 128;
  localparam int unsigned MaxBytes = 65535;

  // Item widths.
  localparam int unsigned CntW   = 16;
  localparam int unsigned AccW   = 32;
  localparam int unsigned OutDW  = 56;

  // Parse phases.
  localparam logic [2:0] PhHdr   = 3'd0;
  localparam logic [2:0] PhVlen  = 3'd1;
  localparam logic [2:0] PhTlHi  = 3'd2;
  localparam logic [2:0] PhTlLo  = 3'd3;
  localparam logic [2:0] PhTopic = 3'd4;
  localparam logic [2:0] PhIdHi  = 3'd5;
  localparam logic [2:0] PhIdLo  = 3'd6;
  localparam logic [2:0] PhPay   = 3'd7;

  // Status codes.
  localparam logic [3:0] StOk        = 4'd0;
  localparam logic [3:0] StShort     = 4'd1;
  localparam logic [3:0] StNotPub    = 4'd2;
  localparam logic [3:0] StRemExceed = 4'd3;
  localparam logic [3:0] StNoTopLen  = 4'd4;
  localparam logic [3:0] StTopicLong = 4'd5;
  localparam logic [3:0] StTopicTrunc = 4'd6;
  localparam logic [3:0] StNoPktId   = 4'd7;
  localparam logic [3:0] StOverlong  = 4'd8;

  // Byte kinds.
  localparam logic [1:0] KindHdr   = 2'd0;
  localparam logic [1:0] KindTopic = 2'd1;
  localparam logic [1:0] KindPay   = 2'd2;

endpackage

### sv/mqtt_publish_stream_parser_unit.sv
// Top level of the MQTT PUBLISH stream parser: input register, one pass of
// parse logic, result register. Depends on mqttpsp_pkg.
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                                  side band
// s_axis    in   [7:0] data_byte                                     tlast end_of_buffer
// m_axis    out  [7:0] byte_out, [11:8] status, [13:12] qos_level,   tlast done_res,
//                [29:14] packet_ident, [36:30] topic_length,          tuser[1:0] byte_kind
//                [52:37] payload_length, [55:53] zero
//
// Throughput is one item per cycle while m_axis does not stall; each item passes
// through the input register, then the result register.
// The parse state advances once per item as it moves from the input register
// into the result register; the final byte of a buffer restarts the parser.
// Reset (rst_ni low) clears the parse state and both valid flags at once.
// A stall on m_axis holds the result register; the input register still takes
// one item, and s_axis_tready drops only when both registers are full.

module mqtt_publish_stream_parser_unit
  import mqttpsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
  input  logic             s_axis_tlast,   // end_of_buffer
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OutDW-1:0] m_axis_tdata,   // byte_out, status, qos_level, packet_ident,
                                           // topic_length, payload_length, zero fill
  output logic [1:0]       m_axis_tuser,   // [1:0] byte_kind
  output logic             m_axis_tlast    // done_res
);

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Result register.
  logic             out_vld_q;
  logic [OutDW-1:0] out_data_q;
  logic [1:0]       out_kind_q;
  logic             out_last_q;

  // Parse state.
  logic [2:0]      phase_q, phase_d;
  logic [AccW-1:0] accum_q, accum_d;
  logic [2:0]      shift_q, shift_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] tlen_q, tlen_d;
  logic [CntW-1:0] tleft_q, tleft_d;
  logic [CntW-1:0] ident_q, ident_d;
  logic [1:0]      qos_q, qos_d;
  logic [CntW-1:0] hdr_end_q, hdr_end_d;
  logic [3:0]      err_q, err_d;

  logic advance;     // move the input item through the parse logic
  logic out_free;    // result register can take a new item

  // Combinational results.
  logic [1:0]      kind;
  logic [3:0]      status;
  logic [CntW-1:0] payload;
  logic [AccW-1:0] len_add;
  logic [CntW:0]   pos_hdr;    // header end plus topic length field
  logic [CntW+1:0] pos_top;    // plus topic bytes
  logic [CntW+1:0] pos_id;     // plus identifier bytes
  logic [AccW:0]   rem_end;    // header end plus remaining length
  logic [CntW+1:0] pay_full;
  logic [OutDW-1:0] res_data;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  // Parse logic: next state, byte kind and the verdict on the final byte.
  always_comb begin
    phase_d   = phase_q;
    accum_d   = accum_q;
    shift_d   = shift_q;
    tlen_d    = tlen_q;
    tleft_d   = tleft_q;
    ident_d   = ident_q;
    qos_d     = qos_q;
    hdr_end_d = hdr_end_q;
    err_d     = err_q;
    kind      = KindHdr;
    len_add   = '0;

    // Saturate the byte count; a buffer past the limit is overlong.
    if (count_q >= CntW'(MaxBytes)) begin
      count_d = count_q;
      err_d   = StOverlong;
    end else begin
      count_d = count_q + CntW'(1);
    end

    // Seven length bits per byte at shifts 0, 7, 14, 21, 28; upper bits wrap off.
    unique case (shift_q)
      3'd0:    len_add = {25'b0, in_byte_q[6:0]};
      3'd1:    len_add = {18'b0, in_byte_q[6:0], 7'b0};
      3'd2:    len_add = {11'b0, in_byte_q[6:0], 14'b0};
      3'd3:    len_add = {4'b0, in_byte_q[6:0], 21'b0};
      3'd4:    len_add = {in_byte_q[3:0], 28'b0};
      default: len_add = '0;
    endcase

    unique case (phase_q)
      PhHdr: begin
        qos_d = in_byte_q[2:1];
        if (in_byte_q[7:4] != 4'h3 && err_d == StOk) begin
          err_d = StNotPub;
        end
        phase_d = PhVlen;
      end
      PhVlen: begin
        if (shift_q < 3'd5) begin
          accum_d = accum_q + len_add;
          shift_d = shift_q + 3'd1;
        end
        if (!in_byte_q[7]) begin
          hdr_end_d = count_d;
          phase_d   = PhTlHi;
        end
      end
      PhTlHi: begin
        tlen_d  = {in_byte_q, 8'h00};
        phase_d = PhTlLo;
      end
      PhTlLo: begin
        tlen_d  = {tlen_q[15:8], in_byte_q};
        tleft_d = tlen_d;
        if (tlen_d > CntW'(MaxTopic - 1) && err_d == StOk) begin
          err_d = StTopicLong;
        end
        if (tlen_d == '0) begin
          phase_d = (qos_q != 2'd0) ? PhIdHi : PhPay;
        end else begin
          phase_d = PhTopic;
        end
      end
      PhTopic: begin
        kind    = KindTopic;
        tleft_d = tleft_q - CntW'(1);
        if (tleft_d == '0) begin
          phase_d = (qos_q != 2'd0) ? PhIdHi : PhPay;
        end
      end
      PhIdHi: begin
        ident_d = {in_byte_q, 8'h00};
        phase_d = PhIdLo;
      end
      PhIdLo: begin
        ident_d = {ident_q[15:8], in_byte_q};
        phase_d = PhPay;
      end
      default: begin
        kind = KindPay;
      end
    endcase

    // Once a hard error is known, tag everything as header.
    if (err_d != StOk) begin
      kind = KindHdr;
    end

    // Verdict, in fixed check order, against the state after this byte.
    pos_hdr  = {1'b0, hdr_end_d} + (CntW + 1)'(2);
    pos_top  = {1'b0, pos_hdr} + {2'b0, tlen_d};
    pos_id   = pos_top + (CntW + 2)'(2);
    rem_end  = {{(AccW - CntW + 1){1'b0}}, hdr_end_d} + {1'b0, accum_d};
    pay_full = {2'b0, count_d} - ((qos_d != 2'd0) ? pos_id : pos_top);
    payload  = '0;
    status   = StOk;
    priority if (err_d == StOverlong) begin
      status = StOverlong;
    end else if (count_d < CntW'(2)) begin
      status = StShort;
    end else if (err_d == StNotPub) begin
      status = StNotPub;
    end else if (phase_d == PhVlen) begin
      status = StRemExceed;
    end else if (rem_end > {{(AccW - CntW + 1){1'b0}}, count_d}) begin
      status = StRemExceed;
    end else if (pos_hdr > {1'b0, count_d}) begin
      status = StNoTopLen;
    end else if (tlen_d > CntW'(MaxTopic - 1)) begin
      status = StTopicLong;
    end else if (pos_top > {2'b0, count_d}) begin
      status = StTopicTrunc;
    end else if (qos_d != 2'd0 && pos_id > {2'b0, count_d}) begin
      status = StNoPktId;
    end else begin
      payload = pay_full[CntW-1:0];
    end

    // Pack the result; verdict fields stay zero but on the final byte, all but status unless it is ok.
    res_data = '0;
    res_data[7:0] = in_byte_q;
    if (in_last_q) begin
      res_data[11:8] = status;
      if (status == StOk) begin
        res_data[13:12] = qos_d;
        res_data[29:14] = (qos_d != 2'd0) ? ident_d : '0;
        res_data[36:30] = tlen_d[6:0];
        res_data[52:37] = payload;
      end
    end
  end

  // Input register: take an item whenever the slot is empty or drains now.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Parse state: advance per item, restart after the final byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHdr;
      accum_q   <= '0;
      shift_q   <= '0;
      count_q   <= '0;
      tlen_q    <= '0;
      tleft_q   <= '0;
      ident_q   <= '0;
      qos_q     <= '0;
      hdr_end_q <= '0;
      err_q     <= StOk;
    end else if (advance) begin
      if (in_last_q) begin
        phase_q   <= PhHdr;
        accum_q   <= '0;
        shift_q   <= '0;
        count_q   <= '0;
        tlen_q    <= '0;
        tleft_q   <= '0;
        ident_q   <= '0;
        qos_q     <= '0;
        hdr_end_q <= '0;
        err_q     <= StOk;
      end else begin
        phase_q   <= phase_d;
        accum_q   <= accum_d;
        shift_q   <= shift_d;
        count_q   <= count_d;
        tlen_q    <= tlen_d;
        tleft_q   <= tleft_d;
        ident_q   <= ident_d;
        qos_q     <= qos_d;
        hdr_end_q <= hdr_end_d;
        err_q     <= err_d;
      end
    end
  end

  // Result register: hold while the sink stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res_data;
      out_kind_q <= kind;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### test/mqtt_publish_stream_parser_unit_tb.sv
// Testbench for mqtt_publish_stream_parser_unit: drives byte buffers on s_axis and
// checks each m_axis item against a scoreboard that parses the same bytes itself.
// Depends on mqttpsp_pkg and the parser RTL.
`timescale 1ns / 1ps

module mqtt_publish_stream_parser_unit_tb;
  import mqttpsp_pkg::*;

  localparam int HoldCycles  = 300;   // long receiver hold-off
  localparam int IdleLimit   = 2000;  // watchdog: cycles with no handshake at all
  localparam int RandomItems = 1100;
  localparam int DrainCycles = 8;     // settle time after the last result

  // One expected m_axis item, unpacked into its fields.
  typedef struct {
    logic [7:0]  byte_val;
    logic [1:0]  kind;
    logic        done;
    logic [3:0]  status;
    logic [1:0]  qos;
    logic [15:0] ident;
    logic [6:0]  tlen;
    logic [15:0] plen;
  } parse_result_t;

  // Scoreboard: parses each accepted byte the way the block should and keeps
  // the expected items in arrival order.
  class publish_scoreboard;
    logic [2:0]  cur_phase;
    logic [31:0] len_accum;
    logic [2:0]  len_shift;
    logic [15:0] byte_cnt;
    logic [15:0] name_len;
    logic [15:0] topic_left;
    logic [15:0] pkt_id;
    logic [1:0]  qos;
    logic [15:0] hdr_end;
    logic [3:0]  err_code;
    parse_result_t expected_q[$];
    int errors;
    int checked;

    function new();
      clear_parse();
      errors = 0;
      checked = 0;
    endfunction

    function void clear_parse();
      cur_phase  = PhHdr;
      len_accum  = '0;
      len_shift  = '0;
      byte_cnt   = '0;
      name_len   = '0;
      topic_left = '0;
      pkt_id     = '0;
      qos        = '0;
      hdr_end    = '0;
      err_code   = StOk;
    endfunction

    // Skip the identifier when QoS is zero.
    function void close_topic();
      cur_phase = (qos != 2'b00) ? PhIdHi : PhPay;
    endfunction

    function void note_byte(input logic [7:0] b, input logic eob);
      parse_result_t r;
      logic [1:0]  k;
      logic [3:0]  st;
      logic [63:0] n;
      logic [63:0] pos;
      logic [63:0] payload;
      k = KindHdr;
      payload = '0;
      // Saturate the count; one byte past the limit marks the buffer overlong.
      if (byte_cnt >= 16'(MaxBytes)) err_code = StOverlong;
      else byte_cnt++;
      case (cur_phase)
        PhHdr: begin
          qos = b[2:1];
          if (b[7:4] != 4'h3 && err_code == StOk) err_code = StNotPub;
          cur_phase = PhVlen;
        end
        PhVlen: begin
          // Past five length bytes the shift has run off 32 bits: add nothing.
          if (len_shift < 3'd5) begin
            len_accum = len_accum + ({25'd0, b[6:0]} << (7 * len_shift));
            len_shift++;
          end
          if (!b[7]) begin
            hdr_end = byte_cnt;
            cur_phase = PhTlHi;
          end
        end
        PhTlHi: begin
          name_len = {b, 8'h00};
          cur_phase = PhTlLo;
        end
        PhTlLo: begin
          name_len = {name_len[15:8], b};
          topic_left = name_len;
          if (name_len > (MaxTopic - 1) && err_code == StOk) err_code = StTopicLong;
          if (topic_left == 16'd0) close_topic();
          else cur_phase = PhTopic;
        end
        PhTopic: begin
          k = KindTopic;
          topic_left--;
          if (topic_left == 16'd0) close_topic();
        end
        PhIdHi: begin
          pkt_id = {b, 8'h00};
          cur_phase = PhIdLo;
        end
        PhIdLo: begin
          pkt_id = {pkt_id[15:8], b};
          cur_phase = PhPay;
        end
        default: k = KindPay;
      endcase
      // Once the buffer is known bad, tag everything as header.
      if (err_code != StOk) k = KindHdr;

      r.byte_val = b;
      r.kind     = k;
      r.done     = 1'b0;
      r.status   = StOk;
      r.qos      = '0;
      r.ident    = '0;
      r.tlen     = '0;
      r.plen     = '0;
      if (eob) begin
        // Verdict in fixed check order; the first failing check wins.
        n = 64'(byte_cnt);
        pos = 64'(hdr_end) + 64'd2;
        st = StOk;
        if (err_code == StOverlong) st = StOverlong;
        else if (n < 64'd2) st = StShort;
        else if (err_code == StNotPub) st = StNotPub;
        else if (cur_phase == PhVlen) st = StRemExceed;
        else if (64'(hdr_end) + 64'(len_accum) > n) st = StRemExceed;
        else if (pos > n) st = StNoTopLen;
        else if (name_len > (MaxTopic - 1)) st = StTopicLong;
        else begin
          pos = pos + 64'(name_len);
          if (pos > n) st = StTopicTrunc;
          else if (qos != 2'b00 && pos + 64'd2 > n) st = StNoPktId;
          else begin
            if (qos != 2'b00) pos = pos + 64'd2;
            payload = n - pos;
          end
        end
        r.done = 1'b1;
        r.status = st;
        if (st == StOk) begin
          r.qos   = qos;
          r.ident = (qos != 2'b00) ? pkt_id : 16'd0;
          r.tlen  = name_len[6:0];
          r.plen  = payload[15:0];
        end
        clear_parse();
      end
      expected_q.push_back(r);
    endfunction

    task report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("ERROR: item %0d %s: got 0x%0h, expected 0x%0h", checked, what, got, want);
    endtask

    task check_result(input logic [OutDW-1:0] d, input logic [1:0] u, input logic l);
      parse_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report("item with nothing pending", 64'(d), 64'd0);
        return;
      end
      want = expected_q.pop_front();
      if (d[7:0] !== want.byte_val)
        report("byte_out", 64'(d[7:0]), 64'(want.byte_val));
      if (u !== want.kind) report("byte_kind", 64'(u), 64'(want.kind));
      if (l !== want.done) report("done_res", 64'(l), 64'(want.done));
      if (d[11:8] !== want.status)
        report("status", 64'(d[11:8]), 64'(want.status));
      if (d[13:12] !== want.qos)
        report("qos_level", 64'(d[13:12]), 64'(want.qos));
      if (d[29:14] !== want.ident)
        report("packet_ident", 64'(d[29:14]), 64'(want.ident));
      if (d[36:30] !== want.tlen)
        report("topic_length", 64'(d[36:30]), 64'(want.tlen));
      if (d[52:37] !== want.plen)
        report("payload_length", 64'(d[52:37]), 64'(want.plen));
      if (d[55:53] !== 3'b000) report("zero fill", 64'(d[55:53]), 64'd0);
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic             s_axis_tlast = 1'b0;    // end_of_buffer
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OutDW-1:0] m_axis_tdata;           // [7:0] byte_out, [11:8] status,
                                            // [13:12] qos_level, [29:14] packet_ident,
                                            // [36:30] topic_length, [52:37] payload_length,
                                            // [55:53] zero
  logic [1:0]       m_axis_tuser;           // [1:0] byte_kind
  logic             m_axis_tlast;           // done_res

  publish_scoreboard sb;
  logic [7:0] buf_q[$];     // bytes of the buffer about to be sent
  int  burst_left = 0;
  int  items_sent = 0;
  bit  gaps_on = 1'b1;
  bit  hold_req = 1'b0;     // ask the receiver for one long hold-off
  int  idle_cycles = 0;

  mqtt_publish_stream_parser_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Offer one byte at the falling edge and hold it until the block takes it.
  // Between bursts, drop tvalid for a random gap.
  task automatic send_item(input logic [7:0] b, input logic eob);
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if (gaps_on)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eob;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    items_sent++;
  endtask

  // Send the whole buffer; mark its final byte.
  task automatic send_buffer();
    foreach (buf_q[i]) send_item(buf_q[i], i == buf_q.size() - 1);
  endtask

  // Stop offering and hold until every expected item has come back.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Build a PUBLISH packet: header, minimal length field, topic length, topic,
  // identifier when QoS is set, payload. adj skews the remaining length.
  function automatic void add_publish(input logic [7:0] hdr, input int tlen,
                                      input logic [15:0] ident, input int plen,
                                      input int adj);
    int rem;
    logic [7:0] v;
    rem = 2 + tlen + plen + adj + ((hdr[2:1] != 2'b00) ? 2 : 0);
    if (rem < 0) rem = 0;
    buf_q.delete();
    buf_q.push_back(hdr);
    do begin
      v = 8'(rem % 128);
      rem = rem / 128;
      if (rem > 0) v[7] = 1'b1;
      buf_q.push_back(v);
    end while (rem > 0);
    buf_q.push_back(8'(tlen >> 8));
    buf_q.push_back(8'(tlen));
    repeat (tlen) buf_q.push_back(8'($urandom));
    if (hdr[2:1] != 2'b00) begin
      buf_q.push_back(ident[15:8]);
      buf_q.push_back(ident[7:0]);
    end
    repeat (plen) buf_q.push_back(8'($urandom));
  endfunction

  // Receiver: ready in runs of random length with short stalls between, long
  // runs now and then, and one long hold-off on request.
  initial begin : receiver
    int on_len;
    int off_len;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        on_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
        off_len = $urandom_range(0, 4);
        repeat (on_len) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b1;
          if (hold_req) break;
        end
        repeat (off_len) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  // Sample both handshakes at the rising edge, feed the scoreboard, and run
  // the watchdog on cycles where nothing moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_byte(s_axis_tdata, s_axis_tlast);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int  start_cnt;
    int  mode;
    int  pick;
    int  tlen;
    int  plen;
    int  adj;
    int  keep;
    int  idx;
    bit  held;
    bit  paused;
    logic [7:0] hdr;
    sb = new();
    held = 1'b0;
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed buffers: one per verdict other than overlong, plus the corner cases of the length field.
    buf_q = '{8'h30};                                   // single byte: short
    send_buffer();
    buf_q = '{8'hFF};                                   // short wins over not publish
    send_buffer();
    buf_q = '{8'h20, 8'h00};                            // wrong packet type
    send_buffer();
    buf_q = '{8'h30, 8'h80};                            // length field never ends
    send_buffer();
    buf_q = '{8'h30, 8'h05, 8'h00};                     // remaining runs off the buffer
    send_buffer();
    buf_q = '{8'h30, 8'h00};                            // no topic length bytes
    send_buffer();
    buf_q = '{8'h30, 8'h02, 8'h00, 8'h80};              // topic length 128
    send_buffer();
    buf_q = '{8'h30, 8'h04, 8'h01, 8'h00, 8'h41, 8'h42}; // high topic length byte set
    send_buffer();
    buf_q = '{8'h30, 8'h02, 8'h00, 8'h03};              // topic cut short
    send_buffer();
    buf_q = '{8'h32, 8'h03, 8'h00, 8'h01, 8'h61};       // QoS 1 without identifier
    send_buffer();
    buf_q = '{8'h30, 8'h02, 8'h00, 8'h00};              // empty topic and payload
    send_buffer();
    // Length field of seven bytes: bytes past the fifth add nothing.
    buf_q = '{8'h3F, 8'h82, 8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'h00,
              8'h00, 8'h00, 8'hFF, 8'hFF};
    send_buffer();
    // Five-byte length that sums to all ones in 32 bits.
    buf_q = '{8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F};
    send_buffer();
    buf_q = '{8'h0F, 8'h02, 8'h00, 8'h00, 8'hAA};       // bad type: all bytes tagged header
    send_buffer();
    add_publish(8'h3F, 127, 16'hFFFF, 3, 0);            // widest topic, QoS 3
    send_buffer();
    add_publish(8'h34, 1, 16'h0000, 1, 0);              // QoS 2, zero identifier
    send_buffer();
    drain();

    // Two well formed buffers sent without gaps.
    gaps_on = 1'b0;
    add_publish(8'h3A, 20, 16'hBEEF, 40, 0);
    send_buffer();
    add_publish(8'h30, 9, 16'h0000, 30, 0);
    send_buffer();
    gaps_on = 1'b1;
    drain();

    // Random buffers: mostly well formed, some broken, some plain noise.
    start_cnt = items_sent;
    while (items_sent - start_cnt < RandomItems) begin
      if (!held && items_sent - start_cnt > 300) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (!paused && items_sent - start_cnt > 800) begin
        drain();
        paused = 1'b1;
      end
      mode = $urandom_range(0, 99);
      if (mode < 82) begin
        hdr = {4'h3, 4'($urandom_range(0, 15))};
        pick = $urandom_range(0, 99);
        tlen = (pick < 80) ? $urandom_range(0, 16) :
               (pick < 95) ? $urandom_range(17, 127) : $urandom_range(128, 300);
        plen = $urandom_range(0, 24);
        adj = 0;
        pick = (mode >= 66) ? $urandom_range(1, 3) : 0;
        if (pick == 1) adj = int'($urandom_range(0, 8)) - 3;
        add_publish(hdr, tlen, 16'($urandom), plen, adj);
        if (pick == 2) begin
          keep = $urandom_range(1, buf_q.size());
          while (buf_q.size() > keep) void'(buf_q.pop_back());
        end
        if (pick == 3) begin
          idx = $urandom_range(0, buf_q.size() - 1);
          buf_q[idx] = buf_q[idx] ^ 8'($urandom_range(1, 255));
        end
      end else begin
        buf_q.delete();
        repeat ($urandom_range(1, 10)) buf_q.push_back(8'($urandom));
      end
      send_buffer();
    end

    drain();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
